>>> rtl/core/platform_interrupt_controller_core_assert.svh
// Assertion macros used by the interrupt controller checker.
`ifndef PLATFORM_INTERRUPT_CONTROLLER_CORE_ASSERT_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_CORE_ASSERT_SVH
// Implication checked on every rising edge outside reset.
`define PICC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("interrupt controller assertion failed");
// Condition that must never be seen.
`define PICC_NEVER(lbl, cond) `PICC_ASSERT(lbl, !(cond))
`endif

>>> rtl/core/picc_pkg.sv
// Shared constants and control types of the interrupt controller.
package picc_pkg;
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_REQ   = 2'd2;

  localparam logic [31:0] ENABLE_OFS    = 32'h0000_2000;
  localparam logic [31:0] ENABLE_STRIDE = 32'h0000_0080;
  localparam logic [31:0] THRESH_OFS    = 32'h0020_0000;
  localparam logic [31:0] THRESH_STRIDE = 32'h0000_1000;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
    logic scan_start;
    logic scan_run;
    logic finish;
  } picc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } picc_sts_t;
endpackage

>>> rtl/core/picc_ram.sv
// Generic RAM with one write port, one read port and registered read.
module picc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/core/picc_ctrl.sv
// Sequencer of the interrupt controller: access, read, scan, respond.
module picc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  picc_pkg::picc_sts_t sts_i,
  output picc_pkg::picc_cmd_t cmd_o
);
  typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_READ, ST_SCAN, ST_FIN} state_e;
  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_EXEC;
        ST_EXEC: state_q <= ST_READ;
        ST_READ: state_q <= ST_SCAN;
        ST_SCAN: if (sts_i.scan_done) state_q <= ST_FIN;
        ST_FIN:  if (sts_i.out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec       = state_q == ST_EXEC;
    cmd_o.capture    = state_q == ST_READ;
    cmd_o.scan_start = state_q == ST_READ;
    cmd_o.scan_run   = state_q == ST_SCAN;
    cmd_o.finish     = (state_q == ST_FIN) && sts_i.out_free;
  end

  assign in_ready_o = state_q == ST_IDLE;
endmodule

>>> rtl/core/picc_dpath.sv
// Register file, source state and arbitration scan of the interrupt controller.
module picc_dpath #(
  parameter int unsigned NUM_SOURCES   = 127,
  parameter int unsigned PRIO_BITS     = 3,
  parameter int unsigned CONTEXT_INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  picc_pkg::picc_cmd_t cmd_i,
  output picc_pkg::picc_sts_t sts_o,
  input  logic [1:0]          in_cmd_i,
  input  logic [25:0]         in_addr_i,
  input  logic [31:0]         in_wdata_i,
  input  logic [6:0]          in_src_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         out_rdata_o,
  output logic                out_irq_o
);
  localparam int unsigned NS1 = NUM_SOURCES + 1;
  localparam int unsigned AW  = $clog2(NS1);
  localparam int unsigned CW  = $clog2(NUM_SOURCES + 2);
  localparam int unsigned ENW = (NUM_SOURCES + 1 + 31) / 32;
  localparam logic [31:0] EN_BASE = picc_pkg::ENABLE_OFS +
                                    32'(CONTEXT_INDEX) * picc_pkg::ENABLE_STRIDE;
  localparam logic [31:0] EN_END  = EN_BASE + 32'(4 * ENW);
  localparam logic [31:0] TH_ADDR = picc_pkg::THRESH_OFS +
                                    32'(CONTEXT_INDEX) * picc_pkg::THRESH_STRIDE;
  localparam logic [31:0] CL_ADDR = TH_ADDR + 32'd4;
  localparam logic [31:0] NS32    = 32'(NUM_SOURCES);

  logic [1:0]  cmd_q;
  logic [25:0] addr_q;
  logic [31:0] wdata_q;
  logic [6:0]  src_q;

  logic [NS1-1:0] en_q, en_d, pend_q, pend_d, isv_q, isv_d, pvld_q, pvld_d;
  logic [PRIO_BITS-1:0] thr_q, thr_d;

  logic [CW-1:0]        cnt_q;
  logic                 cmp_vld_q;
  logic [AW-1:0]        cmp_idx_q;
  logic [AW-1:0]        best_q;
  logic [PRIO_BITS-1:0] bprio_q;
  logic                 more_q;
  logic                 rvld_q;
  logic [31:0]          rd_q;

  logic                 out_vld_q;
  logic [31:0]          out_rdata_q;
  logic                 out_irq_q;

  logic [31:0] addr32, word32, src32, enw32;
  logic aligned, is_rd, is_wr, prio_hit, en_hit, th_hit, cl_hit, claim_rd, issue;
  logic [ENW*32-1:0] en_pad;
  logic [31:0] en_word;
  logic [AW-1:0] raddr;
  logic [PRIO_BITS-1:0] ram_dout, prio_val;
  logic qual;

  // Decode the held request.
  always_comb begin
    addr32   = 32'(addr_q);
    word32   = 32'(addr_q[25:2]);
    src32    = 32'(src_q);
    aligned  = addr_q[1:0] == 2'b00;
    is_rd    = cmd_q == picc_pkg::CMD_READ;
    is_wr    = cmd_q == picc_pkg::CMD_WRITE;
    prio_hit = aligned && word32 >= 32'd1 && word32 <= NS32;
    en_hit   = aligned && !prio_hit && addr32 >= EN_BASE && addr32 < EN_END;
    th_hit   = aligned && !prio_hit && !en_hit && addr32 == TH_ADDR;
    cl_hit   = aligned && !prio_hit && !en_hit && addr32 == CL_ADDR;
    claim_rd = cl_hit && is_rd;
    enw32    = (addr32 - EN_BASE) >> 2;
    en_pad   = '0;
    en_pad[NS1-1:0] = en_q;
    en_word  = '0;
    for (int w = 0; w < ENW; w++) begin
      if (enw32 == 32'(w)) en_word = en_pad[w*32 +: 32];
    end
  end

  // Next state of the per-source bits and the threshold.
  always_comb begin
    en_d   = en_q;
    pend_d = pend_q;
    isv_d  = isv_q;
    pvld_d = pvld_q;
    thr_d  = thr_q;
    if (cmd_i.exec) begin
      for (int s = 1; s < NS1; s++) begin
        if (cmd_q == picc_pkg::CMD_REQ && src32 == 32'(s) && !pend_q[s] && !isv_q[s]) begin
          pend_d[s] = 1'b1;
        end
        if (is_wr && prio_hit && word32 == 32'(s)) pvld_d[s] = 1'b1;
        if (is_wr && cl_hit && wdata_q == 32'(s)) isv_d[s] = 1'b0;
        if (is_wr && en_hit && enw32 == 32'(s / 32)) en_d[s] = wdata_q[s % 32];
      end
      if (is_wr && th_hit) thr_d = wdata_q[PRIO_BITS-1:0];
    end
    if (cmd_i.finish && claim_rd && best_q != '0) begin
      pend_d[best_q] = 1'b0;
      isv_d[best_q]  = 1'b1;
    end
  end

  assign raddr    = cmd_i.scan_run ? cnt_q[AW-1:0] : word32[AW-1:0];
  assign prio_val = rvld_q ? ram_dout : '0;
  assign qual     = cmp_vld_q && pend_q[cmp_idx_q] && en_q[cmp_idx_q] && (prio_val > thr_q);
  assign issue    = cnt_q <= CW'(NUM_SOURCES);

  picc_ram #(.Width(PRIO_BITS), .Depth(NS1)) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && is_wr && prio_hit),
    .waddr_i (word32[AW-1:0]),
    .wdata_i (wdata_q[PRIO_BITS-1:0]),
    .raddr_i (raddr),
    .rdata_o (ram_dout)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= in_cmd_i;
      addr_q  <= in_addr_i;
      wdata_q <= in_wdata_i;
      src_q   <= in_src_i;
    end
    rvld_q <= pvld_q[raddr];
    if (cmd_i.capture) begin
      if (is_rd && prio_hit)    rd_q <= 32'(prio_val);
      else if (is_rd && en_hit) rd_q <= en_word;
      else if (is_rd && th_hit) rd_q <= 32'(thr_q);
      else                      rd_q <= '0;
    end
    if (cmd_i.finish) begin
      out_rdata_q <= claim_rd ? 32'(best_q) : rd_q;
      out_irq_q   <= claim_rd ? more_q : (best_q != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= '0;
      pend_q    <= '0;
      isv_q     <= '0;
      pvld_q    <= '0;
      thr_q     <= '0;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      best_q    <= '0;
      bprio_q   <= '0;
      more_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      en_q   <= en_d;
      pend_q <= pend_d;
      isv_q  <= isv_d;
      pvld_q <= pvld_d;
      thr_q  <= thr_d;
      if (cmd_i.scan_start) begin
        cnt_q     <= CW'(1);
        cmp_vld_q <= 1'b0;
        best_q    <= '0;
        bprio_q   <= '0;
        more_q    <= 1'b0;
      end else if (cmd_i.scan_run) begin
        cmp_vld_q <= issue;
        cmp_idx_q <= cnt_q[AW-1:0];
        if (issue) cnt_q <= cnt_q + CW'(1);
        if (qual) begin
          if (best_q != '0) more_q <= 1'b1;
          if (best_q == '0 || prio_val > bprio_q) begin
            best_q  <= cmp_idx_q;
            bprio_q <= prio_val;
          end
        end
      end
      if (cmd_i.finish) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  assign sts_o.scan_done = cmp_vld_q && cmp_idx_q == AW'(NUM_SOURCES);
  assign sts_o.out_free  = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_rdata_o = out_rdata_q;
  assign out_irq_o   = out_irq_q;
endmodule

>>> rtl/core/platform_interrupt_controller_core.sv
// Requests are taken one at a time; the arbitration scan reads the
// priority RAM through its single read port, one source a cycle, after every request.
// The response register lets a new request be accepted while the previous response waits.
// Reset (rst_ni low, asynchronous): priorities, enables, pending, in-service and the
// threshold read as zero at once; no clearing pass is needed.
module platform_interrupt_controller_core #(
  parameter int unsigned NUM_SOURCES   = 127,
  parameter int unsigned PRIO_BITS     = 3,
  parameter int unsigned CONTEXT_INDEX = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: addr [25:0], wdata [57:26], src_id [64:58], zero fill [71:65]
  input  logic [picc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // tuser: cmd [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: rdata [31:0], irq [32], zero fill [39:33]
  output logic [picc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  picc_pkg::picc_cmd_t cmd;
  picc_pkg::picc_sts_t sts;
  logic [31:0] rdata;
  logic        irq;

  // Sequence each request: access, capture read data, scan all sources, respond.
  picc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold source state, run the arbitration and drive the response register.
  picc_dpath #(
    .NUM_SOURCES   (NUM_SOURCES),
    .PRIO_BITS     (PRIO_BITS),
    .CONTEXT_INDEX (CONTEXT_INDEX)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_cmd_i    (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[25:0]),
    .in_wdata_i  (s_axis_tdata[57:26]),
    .in_src_i    (s_axis_tdata[64:58]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rdata_o (rdata),
    .out_irq_o   (irq)
  );

  // Pack the response; unused upper bits stay zero.
  assign m_axis_tdata = {7'd0, irq, rdata};
endmodule

>>> rtl/core/picc_checker.sv
// Port-level checks of the interrupt controller, bound to the top level.
`include "platform_interrupt_controller_core_assert.svh"
module picc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  // One request at a time: no accept right after an accept.
  `PICC_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  // A response cannot appear the cycle after its request was taken.
  `PICC_ASSERT(a_no_instant_resp, (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
  // Response fill bits stay zero.
  `PICC_NEVER(a_fill_zero, m_axis_tvalid && m_axis_tdata[39:33] != 7'd0)
  // A waiting response is held.
  `PICC_ASSERT(a_resp_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
endmodule

bind platform_interrupt_controller_core picc_checker u_picc_checker (.*);

>>> sim/platform_interrupt_controller_core_tb.sv
// Self-checking testbench for the single-context interrupt controller core.
module platform_interrupt_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSRC = 127;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [25:0] ENABLE_OFS26 = 26'(picc_pkg::ENABLE_OFS);
  localparam logic [25:0] THRESH_OFS26 = 26'(picc_pkg::THRESH_OFS);
  localparam logic [25:0] CLAIM_OFS = THRESH_OFS26 + 26'd4;
  localparam int unsigned SCAN_CYCLES = NSRC + 5;
  localparam int unsigned WATCHDOG_LIMIT = 20 * (SCAN_CYCLES + 64);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [picc_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = picc_pkg::CMD_READ;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [picc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  platform_interrupt_controller_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
  } plic_resp_t;

  // Shadow copy of the controller's state.
  logic [2:0] prio_q [NSRC+1];
  logic       enable_q [NSRC+1];
  logic       pending_q [NSRC+1];
  logic       in_service_q [NSRC+1];
  logic [2:0] threshold_q;

  plic_resp_t expected_resp_q[$];
  int unsigned mismatch_count = 0;
  int unsigned resp_count = 0;
  int unsigned claim_hits = 0;
  int unsigned idle_cycles = 0;
  bit draining = 1'b0;

  function automatic int unsigned best_source();
    int unsigned best;
    best = 0;
    for (int unsigned s = 1; s <= NSRC; s++) begin
      if (pending_q[s] && enable_q[s] && prio_q[s] > threshold_q &&
          (best == 0 || prio_q[s] > prio_q[best])) best = s;
    end
    return best;
  endfunction

  // Advance the shadow state by one request and return its response.
  function automatic plic_resp_t plic_predict(logic [1:0] cmd, logic [25:0] addr,
                                              logic [31:0] wdata, logic [6:0] src);
    plic_resp_t r;
    int unsigned w, s, sel;
    r = '0;
    if (cmd == picc_pkg::CMD_REQ) begin
      if (src != 0 && !pending_q[src] && !in_service_q[src]) pending_q[src] = 1'b1;
    end else if ((cmd == picc_pkg::CMD_READ || cmd == picc_pkg::CMD_WRITE) &&
                 addr[1:0] == 2'b00) begin
      w = 32'(addr >> 2);
      if (w >= 1 && w <= NSRC) begin
        if (cmd == picc_pkg::CMD_WRITE) prio_q[w] = wdata[2:0];
        else r.rdata = 32'(prio_q[w]);
      end else if (addr >= ENABLE_OFS26 && addr < ENABLE_OFS26 + 26'd16) begin
        w = 32'((addr - ENABLE_OFS26) >> 2);
        for (int unsigned b = 0; b < 32; b++) begin
          s = w * 32 + b;
          if (s >= 1 && s <= NSRC) begin
            if (cmd == picc_pkg::CMD_WRITE) enable_q[s] = wdata[b];
            else r.rdata[b] = enable_q[s];
          end
        end
      end else if (addr == THRESH_OFS26) begin
        if (cmd == picc_pkg::CMD_WRITE) threshold_q = wdata[2:0];
        else r.rdata = 32'(threshold_q);
      end else if (addr == CLAIM_OFS) begin
        if (cmd == picc_pkg::CMD_WRITE) begin
          if (wdata >= 1 && wdata <= NSRC) in_service_q[wdata] = 1'b0;
        end else begin
          sel = best_source();
          if (sel != 0) begin
            pending_q[sel] = 1'b0;
            in_service_q[sel] = 1'b1;
            claim_hits++;
          end
          r.rdata = 32'(sel);
        end
      end
    end
    r.irq = best_source() != 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned random_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one request; the expectation is recorded when it is accepted.
  // Valid stays high into the next request when no gap follows.
  task automatic send_request(logic [1:0] cmd, logic [25:0] addr,
                              logic [31:0] wdata = '0, logic [6:0] src = '0);
    int unsigned gap;
    gap = random_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, src, wdata, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_resp_q.push_back(plic_predict(cmd, addr, wdata, src));
  endtask

  // Check each accepted response against the oldest expectation.
  always @(posedge clk_i) begin
    plic_resp_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[32]};
      resp_count++;
      if (expected_resp_q.size() == 0) begin
        report_mismatch("unexpected response", got.rdata, 32'd0);
      end else begin
        want = expected_resp_q.pop_front();
        if (got.rdata !== want.rdata) report_mismatch("rdata", got.rdata, want.rdata);
        if (got.irq !== want.irq) report_mismatch("irq", 32'(got.irq), 32'(want.irq));
      end
    end
  end

  // Stall the response side at random, with quiet stretches of no stalls.
  always @(posedge clk_i) begin
    if (draining || ($urandom_range(0, 7) < 3)) m_axis_tready <= 1'b1;
    else m_axis_tready <= (random_gap() == 0);
  end

  // End the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d responses pending", expected_resp_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [25:0] random_addr();
    case ($urandom_range(0, 9))
      0, 1:    return 26'($urandom_range(0, 128)) << 2;
      2:       return ENABLE_OFS26 + (26'($urandom_range(0, 4)) << 2);
      3:       return THRESH_OFS26;
      4, 5, 6: return CLAIM_OFS;
      7:       return 26'($urandom);
      default: return 26'($urandom_range(0, 600)) | 26'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic test_directed_map();
    send_request(picc_pkg::CMD_READ, CLAIM_OFS);
    send_request(picc_pkg::CMD_WRITE, 26'd0, 32'hFFFF_FFFF);       // source zero priority
    send_request(picc_pkg::CMD_READ, 26'd0);
    send_request(picc_pkg::CMD_WRITE, 26'(4 * NSRC), 32'hFFFF_FFFF); // wide value keeps low bits
    send_request(picc_pkg::CMD_READ, 26'(4 * NSRC));
    send_request(picc_pkg::CMD_WRITE, 26'd4, 32'd5);
    send_request(picc_pkg::CMD_WRITE, ENABLE_OFS26, 32'hFFFF_FFFF);
    send_request(picc_pkg::CMD_WRITE, ENABLE_OFS26 + 26'd12, 32'hFFFF_FFFF);
    send_request(picc_pkg::CMD_READ, ENABLE_OFS26);
    send_request(picc_pkg::CMD_READ, ENABLE_OFS26 + 26'd12);
    send_request(picc_pkg::CMD_WRITE, THRESH_OFS26, 32'hFFFF_FFFA);
    send_request(picc_pkg::CMD_READ, THRESH_OFS26);
    send_request(picc_pkg::CMD_WRITE, THRESH_OFS26, 32'd0);
    send_request(picc_pkg::CMD_REQ, 26'h3FF_FFFF, 32'hFFFF_FFFF, 7'd0);  // ignored source
    send_request(picc_pkg::CMD_REQ, '0, '0, 7'd127);
    send_request(picc_pkg::CMD_REQ, '0, '0, 7'd1);
    send_request(picc_pkg::CMD_REQ, '0, '0, 7'd1);                  // already pending
    send_request(picc_pkg::CMD_READ, CLAIM_OFS);
    send_request(picc_pkg::CMD_REQ, '0, '0, 7'd127);                // in service
    send_request(picc_pkg::CMD_READ, 26'd5);                        // unaligned
    send_request(picc_pkg::CMD_WRITE, CLAIM_OFS, 32'd200);          // out of range complete
    send_request(picc_pkg::CMD_WRITE, CLAIM_OFS, 32'd127);
    send_request(CMD_UNUSED, CLAIM_OFS, 32'd1, 7'd1);
    send_request(picc_pkg::CMD_READ, CLAIM_OFS);
    send_request(picc_pkg::CMD_READ, 26'h3FF_FFFC);
  endtask

  // Raise/claim/complete flows with random priorities, plus noise.
  task automatic test_random_traffic(int unsigned count);
    logic [6:0] src;
    for (int unsigned i = 0; i < count; i++) begin
      src = 7'($urandom);
      case ($urandom_range(0, 9))
        0:       send_request(picc_pkg::CMD_WRITE, 26'(src) << 2, $urandom);
        1:       send_request(picc_pkg::CMD_WRITE,
                              ENABLE_OFS26 + (26'($urandom_range(0, 3)) << 2), $urandom);
        2:       send_request(picc_pkg::CMD_WRITE, THRESH_OFS26, 32'($urandom_range(0, 7)));
        3, 4:    send_request(picc_pkg::CMD_REQ, 26'($urandom), $urandom, src);
        5:       send_request(picc_pkg::CMD_READ, CLAIM_OFS);
        6:       send_request(picc_pkg::CMD_WRITE, CLAIM_OFS,
                              ($urandom_range(0, 9) == 0) ? $urandom : 32'(src));
        7:       send_request(picc_pkg::CMD_READ, random_addr());
        8:       send_request(2'($urandom), random_addr(), $urandom, src);
        default: send_request(picc_pkg::CMD_WRITE, random_addr(), $urandom, src);
      endcase
    end
  endtask

  initial begin
    for (int s = 0; s <= NSRC; s++) begin
      prio_q[s] = '0; enable_q[s] = 1'b0; pending_q[s] = 1'b0; in_service_q[s] = 1'b0;
    end
    threshold_q = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_map();
    test_random_traffic(1200);
    s_axis_tvalid <= 1'b0;
    draining = 1'b1;
    while (expected_resp_q.size() != 0) @(posedge clk_i);
    repeat (2 * SCAN_CYCLES) @(posedge clk_i);
    $display("covered %0d responses, %0d claims that returned a source",
             resp_count, claim_hits);
    if (mismatch_count == 0 && expected_resp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
